[rtl/double_ended_queue_defines.svh]
// ----------------------------------------------------------------------------
// double_ended_queue_defines.svh
// Assertion macros shared by the deque checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define DEQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define DEQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Types, codes and widths shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int MODE_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [MODE_W-1:0]          mode_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic signed [WORD_W-1:0]   word_t;

    // Operation codes
    localparam mode_t MODE_PUSH_FRONT = 3'd0;
    localparam mode_t MODE_PUSH_BACK  = 3'd1;
    localparam mode_t MODE_POP_FRONT  = 3'd2;
    localparam mode_t MODE_POP_BACK   = 3'd3;
    localparam mode_t MODE_QUERY      = 3'd4;

    // Status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // Popped word when nothing was removed
    localparam word_t WORD_NONE = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } state_t;

    typedef struct packed {
        logic exec;     // apply the accepted item to pointers, count and store
        logic rd;       // read the words at both ends
        logic load;     // move the result into the output register
    } ctrl_cmd_t;

endpackage

[rtl/deq_req_if.sv]
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel: one operation per transfer.
// ----------------------------------------------------------------------------
interface deq_req_if;

    logic             valid;
    logic             ready;
    deq_pkg::mode_t   mode;
    deq_pkg::word_t   value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);

endinterface

[rtl/deq_rsp_if.sv]
// ----------------------------------------------------------------------------
// deq_rsp_if
// Response channel: one result per transfer.
// ----------------------------------------------------------------------------
interface deq_rsp_if;

    logic                               valid;
    logic                               ready;
    deq_pkg::word_t                     popped_value;
    deq_pkg::status_t                   status;
    logic [deq_pkg::COUNT_W-1:0]        item_count;
    logic                               is_empty;
    deq_pkg::word_t                     front_value;
    deq_pkg::word_t                     back_value;

    modport source (output valid, output popped_value, output status, output item_count,
                    output is_empty, output front_value, output back_value, input ready);
    modport sink   (input valid, input popped_value, input status, input item_count,
                    input is_empty, input front_value, input back_value, output ready);

endinterface

[rtl/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: accept, read both ends, load the output register.
// ----------------------------------------------------------------------------
module deq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output deq_pkg::ctrl_cmd_t  cmd
);

    deq_pkg::state_t state_reg;
    deq_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = deq_pkg::S_READ;
                end
            end
            deq_pkg::S_READ:
            begin
                state_next = deq_pkg::S_LOAD;
            end
            deq_pkg::S_LOAD:
            begin
                if (out_free)
                begin
                    state_next = deq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.exec  = req_valid;
            end
            deq_pkg::S_READ:
            begin
                cmd.rd = 1'b1;
            end
            deq_pkg::S_LOAD:
            begin
                cmd.load = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Hold the result until taken; a new load replaces it in the same cycle
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

[rtl/deq_dp.sv]
// ----------------------------------------------------------------------------
// deq_dp
// Ring store, end pointers, word count and output register.
// ----------------------------------------------------------------------------
module deq_dp
#(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  deq_pkg::ctrl_cmd_t           cmd,
    input  deq_pkg::mode_t               mode,
    input  deq_pkg::word_t               value,
    output deq_pkg::word_t               popped_value,
    output deq_pkg::status_t             status,
    output logic [deq_pkg::COUNT_W-1:0]  item_count,
    output logic                         is_empty,
    output deq_pkg::word_t               front_value,
    output deq_pkg::word_t               back_value
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int COUNT_W = deq_pkg::COUNT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    deq_pkg::word_t mem [DEPTH];

    logic [PTR_W-1:0]  front_ptr_reg, front_ptr_next;
    logic [PTR_W-1:0]  back_ptr_reg,  back_ptr_next;
    logic [CNT_W-1:0]  count_reg,     count_next;

    deq_pkg::word_t    pop_word_reg,  pop_word_next;
    deq_pkg::status_t  stat_reg,      stat_next;

    deq_pkg::word_t    rd_front_reg;
    deq_pkg::word_t    rd_back_reg;

    deq_pkg::word_t                popped_value_reg;
    deq_pkg::status_t              status_reg;
    logic [COUNT_W-1:0]            item_count_reg;
    logic                          is_empty_reg;
    deq_pkg::word_t                front_value_reg;
    deq_pkg::word_t                back_value_reg;

    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic              full;
    logic              empty;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);

    // Pops take the end words from the last result, which always holds them
    always_comb
    begin
        front_ptr_next = front_ptr_reg;
        back_ptr_next  = back_ptr_reg;
        count_next     = count_reg;
        pop_word_next  = deq_pkg::WORD_NONE;
        stat_next      = deq_pkg::ST_OK;
        wr_en          = 1'b0;
        wr_addr        = back_ptr_reg;
        case (mode)
            deq_pkg::MODE_PUSH_FRONT:
            begin
                if (full)
                begin
                    stat_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    front_ptr_next = ptr_dec(front_ptr_reg);
                    wr_en          = 1'b1;
                    wr_addr        = ptr_dec(front_ptr_reg);
                    count_next     = count_reg + 1'b1;
                end
            end
            deq_pkg::MODE_PUSH_BACK:
            begin
                if (full)
                begin
                    stat_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    back_ptr_next = ptr_inc(back_ptr_reg);
                    wr_en         = 1'b1;
                    count_next    = count_reg + 1'b1;
                end
            end
            deq_pkg::MODE_POP_FRONT:
            begin
                if (empty)
                begin
                    stat_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    pop_word_next  = front_value_reg;
                    front_ptr_next = ptr_inc(front_ptr_reg);
                    count_next     = count_reg - 1'b1;
                end
            end
            deq_pkg::MODE_POP_BACK:
            begin
                if (empty)
                begin
                    stat_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    pop_word_next = back_value_reg;
                    back_ptr_next = ptr_dec(back_ptr_reg);
                    count_next    = count_reg - 1'b1;
                end
            end
            default:
            begin
                stat_next = deq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_ptr_reg <= '0;
            back_ptr_reg  <= '0;
            count_reg     <= '0;
        end
        else if (cmd.exec)
        begin
            front_ptr_reg <= front_ptr_next;
            back_ptr_reg  <= back_ptr_next;
            count_reg     <= count_next;
        end
    end

    // Word store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (cmd.rd)
        begin
            rd_front_reg <= mem[front_ptr_reg];
            rd_back_reg  <= mem[ptr_dec(back_ptr_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            pop_word_reg <= pop_word_next;
            stat_reg     <= stat_next;
        end
        if (cmd.load)
        begin
            popped_value_reg <= pop_word_reg;
            status_reg       <= stat_reg;
            item_count_reg   <= COUNT_W'(count_reg);
            is_empty_reg     <= empty;
            front_value_reg  <= empty ? '0 : rd_front_reg;
            back_value_reg   <= empty ? '0 : rd_back_reg;
        end
    end

    assign popped_value = popped_value_reg;
    assign status       = status_reg;
    assign item_count   = item_count_reg;
    assign is_empty     = is_empty_reg;
    assign front_value  = front_value_reg;
    assign back_value   = back_value_reg;

endmodule

[rtl/double_ended_queue.sv]
// A result is registered: after its request transfer, each item applies its update, then
// reads both end words from the store's two read ports, then loads the result once the
// output register is free. A new request is taken only after the last item has loaded.
// A finished result may wait in the output register while the next item runs.
// Reset (rst_n, asynchronous, active low) empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue
// Ring-buffer deque of signed 32-bit words with push and pop at both ends.
// ----------------------------------------------------------------------------
module double_ended_queue
#(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    deq_req_if.sink     req,
    deq_rsp_if.source   rsp
);

    // Command bundle from the sequencer to the datapath
    deq_pkg::ctrl_cmd_t cmd;

    // Sequencer: owns both handshakes. It takes a request only when idle,
    // walks the item through the read pass and loads the output register
    // once that register is empty or its contents are being transferred.
    deq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Datapath: front and back pointers wrap modulo DEPTH in both directions;
    // the front pointer names the front word, the back pointer the slot after
    // the back word. Refused pushes and pops leave the state untouched.
    deq_dp
    #(
        .DEPTH (DEPTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (req.mode),
        .value        (req.value),
        .popped_value (rsp.popped_value),
        .status       (rsp.status),
        .item_count   (rsp.item_count),
        .is_empty     (rsp.is_empty),
        .front_value  (rsp.front_value),
        .back_value   (rsp.back_value)
    );

endmodule

[rtl/deq_checker.sv]
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module deq_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input deq_pkg::word_t               popped_value,
    input deq_pkg::status_t             status,
    input logic [deq_pkg::COUNT_W-1:0]  item_count,
    input logic                         is_empty,
    input deq_pkg::word_t               front_value,
    input deq_pkg::word_t               back_value
);

    // A stalled result stays valid and holds its popped word, status, count and front word
    `DEQ_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(popped_value) && $stable(status) && $stable(item_count) && $stable(front_value), "stalled result changed")

    // One item at a time: no transfer in the cycle after one
    `DEQ_ASSERT_NXT(a_req_gap, req_valid && req_ready, !req_ready, "request taken while busy")

    // Empty flag, count and end words agree
    `DEQ_ASSERT_IMP(a_empty_view, rsp_valid && is_empty, item_count == '0 && front_value == '0 && back_value == '0, "empty result inconsistent")

    // A refused item removes nothing
    `DEQ_ASSERT_IMP(a_refused_pop, rsp_valid && status != deq_pkg::ST_OK, popped_value == deq_pkg::WORD_NONE, "refused item popped a word")

endmodule

bind double_ended_queue deq_checker u_deq_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .popped_value (rsp.popped_value),
    .status       (rsp.status),
    .item_count   (rsp.item_count),
    .is_empty     (rsp.is_empty),
    .front_value  (rsp.front_value),
    .back_value   (rsp.back_value)
);
